### rtl/acr_pkg.sv
// acr_pkg: shared widths, register indexes, codes and handshake structs
// for the channel remix block; no dependencies
package acr_pkg;

	localparam int SAMPLE_W = 24;
	localparam int CH_W = 4;
	localparam int CFG_W = 5;
	localparam int ACC_W = 28;
	localparam int IDX_W = 2;
	localparam int WCODE_W = 2;
	localparam int DEFAULT_MAX_CHANNELS = 16;

	localparam logic [IDX_W-1:0] REG_OLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_NEW = 2'd1;
	localparam logic [IDX_W-1:0] REG_WIDTH = 2'd2;

	localparam logic [WCODE_W-1:0] WIDTH_8 = 2'd0;
	localparam logic [WCODE_W-1:0] WIDTH_16 = 2'd1;

	localparam logic [CFG_W-1:0] OLD_RST = 5'd2;
	localparam logic [CFG_W-1:0] NEW_RST = 5'd2;
	localparam logic [WCODE_W-1:0] WIDTH_RST = WIDTH_16;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_EMIT,
		ACT_MIX
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic div_start;
		logic load_quot;
		logic emit;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic div_done;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

### rtl/acr_div.sv
// acr_div: serial restoring divider, one quotient bit per cycle,
// truncating toward zero; depends on acr_pkg
module acr_div
	import acr_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [ACC_W-1:0]    dividend,
	input  logic        [CFG_W-1:0]    divisor,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] quotient
);

	localparam int CNT_W = $clog2(ACC_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] mag_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] den_q;
	logic             neg_q;

	logic [CFG_W:0]   trial;
	logic             ge;
	logic [CFG_W:0]   trial_sub;
	logic [ACC_W-1:0] abs_in;
	logic [ACC_W-1:0] signed_q;

	assign trial = {rem_q, mag_q[ACC_W-1]};
	assign ge = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};
	assign abs_in = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
	assign signed_q = neg_q ? ACC_W'(-mag_q) : mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(ACC_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= abs_in;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[ACC_W-1];
		end else if (busy_q) begin
			mag_q <= {mag_q[ACC_W-2:0], ge};
			rem_q <= ge ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = signed_q[SAMPLE_W-1:0];

endmodule

### rtl/acr_dp.sv
// acr_dp: datapath with config registers, frame position, mix accumulator,
// emit counter and output register; depends on acr_pkg and acr_div
module acr_dp
	import acr_pkg::*;
#(
	parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic        [IDX_W-1:0]    cfg_index,
	input  logic        [CFG_W-1:0]    cfg_data,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	input  logic                       out_stall,
	input  cmd_t                       cmd,
	output status_t                    status,
	output logic                       out_valid,
	output logic signed [SAMPLE_W-1:0] out_sample,
	output logic        [CH_W-1:0]     out_channel,
	output logic                       end_of_frame,
	output logic                       last_of_run
);

	localparam logic [CFG_W-1:0] LIM = CFG_W'((MAX_CHANNELS > 16) ? 16 : MAX_CHANNELS);

	logic        [CFG_W-1:0]    old_q;
	logic        [CFG_W-1:0]    new_q;
	logic        [WCODE_W-1:0]  width_q;
	logic        [CH_W-1:0]     pos_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] samp_q;
	logic        [CH_W-1:0]     ch_q;
	logic        [CH_W-1:0]     stop_q;
	logic                       eof_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic        [CH_W-1:0]     out_channel_q;
	logic                       eof_out_q;
	logic                       last_out_q;

	logic        [CFG_W-1:0]    oc;
	logic        [CFG_W-1:0]    nc;
	logic        [CFG_W-1:0]    nc_m1;
	logic        [CFG_W-1:0]    pos;
	logic                       frame_end;
	logic signed [SAMPLE_W-1:0] s;
	logic signed [ACC_W-1:0]    acc_sum;
	logic        [CFG_W-1:0]    cnt;
	act_t                       act;
	logic        [CH_W-1:0]     start_ch;
	logic        [CH_W-1:0]     stop_ch;
	logic                       eof_fl;
	logic                       div_done;
	logic signed [SAMPLE_W-1:0] quot;

	function automatic logic [CFG_W-1:0] clamp_ch(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) r = CFG_W'(1);
		else if (v > LIM) r = LIM;
		return r;
	endfunction

	assign oc = clamp_ch(old_q);
	assign nc = clamp_ch(new_q);
	assign nc_m1 = nc - 1'b1;
	assign pos = ({1'b0, pos_q} >= oc) ? '0 : {1'b0, pos_q};
	assign frame_end = pos == (oc - 1'b1);
	assign cnt = oc - nc + 1'b1;

	always_comb begin
		case (width_q)
			WIDTH_8:  s = {{(SAMPLE_W-8){in_sample[7]}}, in_sample[7:0]};
			WIDTH_16: s = {{(SAMPLE_W-16){in_sample[15]}}, in_sample[15:0]};
			default:  s = in_sample;
		endcase
	end

	assign acc_sum = acc_q + {{(ACC_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};

	always_comb begin
		act = ACT_EMIT;
		start_ch = pos[CH_W-1:0];
		stop_ch = pos[CH_W-1:0];
		eof_fl = frame_end;
		if (nc < oc) begin
			eof_fl = 1'b0;
			if (pos < nc_m1) begin
				act = ACT_EMIT;
			end else if (frame_end) begin
				act = ACT_MIX;
				start_ch = nc_m1[CH_W-1:0];
				stop_ch = nc_m1[CH_W-1:0];
				eof_fl = 1'b1;
			end else begin
				act = ACT_NONE;
			end
		end else if (nc > oc) begin
			if (frame_end) begin
				stop_ch = nc_m1[CH_W-1:0];
			end
		end
	end

	acr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (acc_sum),
		.divisor  (cnt),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_q <= OLD_RST;
			new_q <= NEW_RST;
			width_q <= WIDTH_RST;
			pos_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OLD: begin
						old_q <= cfg_data;
						pos_q <= '0;
						acc_q <= '0;
					end
					REG_NEW: begin
						new_q <= cfg_data;
						pos_q <= '0;
						acc_q <= '0;
					end
					REG_WIDTH: begin
						width_q <= cfg_data[WCODE_W-1:0];
						pos_q <= '0;
						acc_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (cmd.take) begin
				pos_q <= frame_end ? '0 : pos[CH_W-1:0] + 1'b1;
				if (act == ACT_MIX) acc_q <= '0;
				else if (act == ACT_NONE) acc_q <= acc_sum;
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			samp_q <= s;
			ch_q <= start_ch;
			stop_q <= stop_ch;
			eof_q <= eof_fl;
		end else if (cmd.load_quot) begin
			samp_q <= quot;
		end else if (cmd.emit) begin
			ch_q <= ch_q + 1'b1;
		end
		if (cmd.emit) begin
			out_sample_q <= samp_q;
			out_channel_q <= ch_q;
			eof_out_q <= eof_q && (ch_q == stop_q);
			last_out_q <= ch_q == stop_q;
		end
	end

	assign status.act = act;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;
	assign status.emit_last = ch_q == stop_q;

	assign out_valid = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_channel = out_channel_q;
	assign end_of_frame = eof_out_q;
	assign last_of_run = last_out_q;

endmodule

### rtl/acr_ctrl.sv
// acr_ctrl: controller state machine sequencing accept, divide and emit
// depends on acr_pkg
module acr_ctrl
	import acr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  status_t status,
	output logic    in_stall,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (status.act)
						ACT_EMIT: state_d = ST_EMIT;
						ACT_MIX:  state_d = ST_DIV;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV: begin
				if (status.div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free && status.emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != ST_IDLE;
		cmd.take = (state_q == ST_IDLE) && in_valid;
		cmd.div_start = (state_q == ST_IDLE) && in_valid && (status.act == ACT_MIX);
		cmd.load_quot = (state_q == ST_DIV) && status.div_done;
		cmd.emit = (state_q == ST_EMIT) && status.out_free;
	end

endmodule

### rtl/audio_channel_remix.sv
// audio_channel_remix: remaps interleaved signed pcm frames from one channel
// count to another. Each input beat is taken only when the block is idle;
// each result it causes, including every extra upmix channel, is then
// loaded into the output register while the output is free. The beat that
// closes a downmix frame waits on a serial divider, one quotient bit per
// cycle over 28 bits. A write to the old, new or width register restarts the frame.
module audio_channel_remix
	import acr_pkg::*;
#(
	parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic        [IDX_W-1:0]    cfg_index,
	input  logic        [CFG_W-1:0]    cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] out_sample,
	output logic        [CH_W-1:0]     out_channel,
	output logic                       end_of_frame,
	output logic                       last_of_run
);

	cmd_t    cmd;
	status_t status;

	acr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	acr_dp #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_sample    (in_sample),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_sample   (out_sample),
		.out_channel  (out_channel),
		.end_of_frame (end_of_frame),
		.last_of_run  (last_of_run)
	);

`ifndef NO_ASSERTIONS
	a_emit_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> in_stall)
		else $error("result loaded while input open");

	a_div_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> in_stall)
		else $error("input open during divide");

	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_frame) |-> last_of_run)
		else $error("end of frame not last of run");
`endif

endmodule

### tb/acr_checker.sv
`timescale 1ns / 100ps
// acr_checker: watches the config port and both beat channels of audio_channel_remix,
// predicts every output beat and compares each one field by field
// depends on acr_pkg for widths, register indexes and width codes
module acr_checker
	import acr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [SAMPLE_W-1:0] in_sample,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [SAMPLE_W-1:0] out_sample,
	input  logic [CH_W-1:0]     out_channel,
	input  logic                end_of_frame,
	input  logic                last_of_run,
	output int                  mismatches,
	output int                  beats_owed
);

	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic [CH_W-1:0]     channel;
		logic                eof;
		logic                last;
	} remix_beat_t;

	remix_beat_t expected_beats[$];

	logic [CFG_W-1:0]        old_count;
	logic [CFG_W-1:0]        new_count;
	logic [WCODE_W-1:0]      width_code;
	logic [CH_W-1:0]         frame_pos;
	logic signed [ACC_W-1:0] mix_sum;

	task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
			input logic [SAMPLE_W-1:0] want);
		$display("%0t remix mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic int unsigned clamp_count(input logic [CFG_W-1:0] v);
		int unsigned lim;
		lim = (DEFAULT_MAX_CHANNELS > 16) ? 16 : DEFAULT_MAX_CHANNELS;
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic logic [SAMPLE_W-1:0] widen(input logic [SAMPLE_W-1:0] raw);
		case (width_code)
			WIDTH_8: return {{16{raw[7]}}, raw[7:0]};
			WIDTH_16: return {{8{raw[15]}}, raw[15:0]};
			default: return raw;
		endcase
	endfunction

	function automatic void expect_beat(input logic [SAMPLE_W-1:0] s, input int unsigned ch,
			input logic eof, input logic last);
		remix_beat_t b;
		b.sample = s;
		b.channel = ch[CH_W-1:0];
		b.eof = eof;
		b.last = last;
		expected_beats.push_back(b);
	endfunction

	// one accepted input sample: queue the beats it causes, advance the frame
	task automatic remix_sample(input logic [SAMPLE_W-1:0] raw);
		int unsigned oc;
		int unsigned nc;
		int unsigned pos;
		int unsigned ch;
		int cnt;
		logic signed [SAMPLE_W-1:0] s;
		logic signed [ACC_W-1:0] avg;
		logic frame_end;
		oc = clamp_count(old_count);
		nc = clamp_count(new_count);
		pos = frame_pos;
		s = widen(raw);
		if (pos >= oc)
			pos = 0;
		frame_end = (pos == oc - 1);
		if (nc == oc) begin
			expect_beat(s, pos, frame_end, 1'b1);
		end else if (nc < oc) begin
			if (pos < nc - 1) begin
				expect_beat(s, pos, 1'b0, 1'b1);
			end else begin
				mix_sum = mix_sum + ACC_W'(s);
				if (frame_end) begin
					cnt = oc - nc + 1;
					avg = ACC_W'(mix_sum / cnt);
					expect_beat(avg[SAMPLE_W-1:0], nc - 1, 1'b1, 1'b1);
					mix_sum = '0;
				end
			end
		end else if (!frame_end) begin
			expect_beat(s, pos, 1'b0, 1'b1);
		end else begin
			for (ch = pos; ch < nc; ch++)
				expect_beat(s, ch, ch == nc - 1, ch == nc - 1);
		end
		frame_pos = frame_end ? '0 : CH_W'(pos + 1);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		remix_beat_t want;
		if (!arst_n) begin
			old_count = OLD_RST;
			new_count = NEW_RST;
			width_code = WIDTH_RST;
			frame_pos = '0;
			mix_sum = '0;
			mismatches = 0;
			expected_beats.delete();
			beats_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OLD: old_count = cfg_data;
					REG_NEW: new_count = cfg_data;
					REG_WIDTH: width_code = cfg_data[WCODE_W-1:0];
					default: ;
				endcase
				// a write to the old, new or width register restarts the frame
				if (cfg_index == REG_OLD || cfg_index == REG_NEW || cfg_index == REG_WIDTH) begin
					frame_pos = '0;
					mix_sum = '0;
				end
			end
			if (in_valid && !in_stall)
				remix_sample(in_sample);
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("beat with none owed", out_sample, '0);
				end else begin
					want = expected_beats.pop_front();
					if (out_sample !== want.sample)
						report_mismatch("out_sample", out_sample, want.sample);
					if (out_channel !== want.channel)
						report_mismatch("out_channel", SAMPLE_W'(out_channel),
							SAMPLE_W'(want.channel));
					if (end_of_frame !== want.eof)
						report_mismatch("end_of_frame", SAMPLE_W'(end_of_frame),
							SAMPLE_W'(want.eof));
					if (last_of_run !== want.last)
						report_mismatch("last_of_run", SAMPLE_W'(last_of_run),
							SAMPLE_W'(want.last));
				end
			end
			beats_owed <= expected_beats.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: clock, reset, config writes, sample beats and output stalls for
// audio_channel_remix, with acr_checker beside it; depends on acr_pkg and the rtl
module tb_top;
	import acr_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int DIRECTED_BEATS = 22;
	localparam int RANDOM_BEATS = 100;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [WCODE_W-1:0] WIDTH_24 = 2'd2;
	localparam logic [WCODE_W-1:0] WIDTH_ODD = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [SAMPLE_W-1:0] in_sample;
	logic                out_valid;
	logic                out_stall;
	logic [SAMPLE_W-1:0] out_sample;
	logic [CH_W-1:0]     out_channel;
	logic                end_of_frame;
	logic                last_of_run;

	int mismatches;
	int beats_owed;
	int in_gap_pct;
	int out_gap_pct;
	int sent;
	int cycles = 0;

	audio_channel_remix dut (.*);

	acr_checker u_checker (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// output stall bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_gap_pct > 0 && $urandom_range(0, 99) < out_gap_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_beat(input logic [SAMPLE_W-1:0] s);
		in_valid <= 1'b1;
		in_sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (beats_owed != 0);
	endtask

	// leaves cfg_we high; the caller lowers it
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic [CFG_W-1:0] old_v, input logic [CFG_W-1:0] new_v,
			input logic [CFG_W-1:0] width_v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_OLD, old_v);
		write_reg(REG_NEW, new_v);
		write_reg(REG_WIDTH, width_v);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_count();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 5'd0;
		if (r == 1)
			return CFG_W'($urandom_range(17, 31));
		if (r < 5)
			return CFG_W'($urandom_range(9, 16));
		return CFG_W'($urandom_range(1, 8));
	endfunction

	initial begin
		logic [CFG_W-1:0] old_v;
		logic [CFG_W-1:0] new_v;
		logic [SAMPLE_W-1:0] smp;
		int unsigned oc;
		int unsigned n;
		cfg_we = 1'b0;
		cfg_index = REG_OLD;
		cfg_data = '0;
		in_valid = 1'b0;
		in_sample = '0;
		arst_n = 1'b0;
		in_gap_pct = 30;
		out_gap_pct = 30;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: stereo passthrough, 16-bit, garbage above the sample bits
		send_beat(24'h007FFF);
		send_beat(24'hFF8000);
		send_beat(24'hAB8000);
		in_valid <= 1'b0;

		// four to one at 24 bits: max sum, min sum, negative average toward zero
		apply_config(5'd4, 5'd1, CFG_W'(WIDTH_24));
		repeat (4) send_beat(24'h7FFFFF);
		repeat (4) send_beat(24'h800000);
		send_beat(24'hFFFFFF);
		send_beat(24'hFFFFFF);
		send_beat(24'h000000);
		send_beat(24'h000001);
		in_valid <= 1'b0;

		// three to two at 8 bits, restarted by a write in mid frame
		apply_config(5'd3, 5'd2, CFG_W'(WIDTH_8));
		send_beat(24'h000080);
		send_beat(24'h12347F);
		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_WIDTH, CFG_W'(WIDTH_8));
		cfg_we <= 1'b0;
		send_beat(24'h000001);
		send_beat(24'h0000FF);
		send_beat(24'h00007F);
		in_valid <= 1'b0;

		// out of range counts and width code 3: one channel up to sixteen
		apply_config(5'd0, 5'd31, CFG_W'(WIDTH_ODD));
		send_beat(24'h123456);
		send_beat(24'h800000);
		in_valid <= 1'b0;

		while (sent < DIRECTED_BEATS + RANDOM_BEATS) begin
			old_v = pick_count();
			new_v = pick_count();
			apply_config(old_v, new_v, CFG_W'($urandom_range(0, 3)));
			oc = (old_v == 0) ? 1 : (old_v > 16) ? 16 : old_v;
			n = oc * $urandom_range(1, 3);
			// sometimes a broken frame, cut off by the next config write
			if ($urandom_range(0, 4) == 0)
				n += $urandom_range(1, oc);
			if (sent >= DIRECTED_BEATS + RANDOM_BEATS - 30) begin
				in_gap_pct = 0;
				out_gap_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: in_gap_pct = 0;
					1: in_gap_pct = 25;
					default: in_gap_pct = 60;
				endcase
				case ($urandom_range(0, 2))
					0: out_gap_pct = 0;
					1: out_gap_pct = 25;
					default: out_gap_pct = 60;
				endcase
			end
			repeat (n) begin
				case ($urandom_range(0, 11))
					0: smp = 24'h00007F;
					1: smp = 24'hFFFF80;
					2: smp = 24'h007FFF;
					3: smp = 24'h7F8000;
					4: smp = 24'h7FFFFF;
					5: smp = 24'h800000;
					default: smp = SAMPLE_W'($urandom);
				endcase
				send_beat(smp);
			end
			in_valid <= 1'b0;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### audio_channel_remix.f
rtl/acr_pkg.sv
rtl/acr_div.sv
rtl/acr_dp.sv
rtl/acr_ctrl.sv
rtl/audio_channel_remix.sv
tb/acr_checker.sv
tb/tb_top.sv
